@@ hw/rtl/rdc_pkg.sv @@
// Package for the radix digit converter: payload types, sequencer states, digit table.
`default_nettype none

package rdc_pkg;

  localparam int unsigned VALUE_BITS = 16;
  localparam int unsigned MAX_RADIX  = 16;
  localparam int unsigned RADIX_W    = 8;
  localparam int unsigned CHAR_W     = 7;

  // Remainder width: remainder < radix <= 16.
  localparam int unsigned REM_W      = 4;
  // Quotient bits resolved per divider pass.
  localparam int unsigned STEP_BITS  = 4;
  localparam int unsigned DIV_STEPS  = VALUE_BITS / STEP_BITS;
  localparam int unsigned STEP_CNT_W = $clog2(DIV_STEPS);

  // Base 2 gives the most digits: one per value bit.
  localparam int unsigned MAX_DIGITS = VALUE_BITS;
  localparam int unsigned DIG_IDX_W  = $clog2(MAX_DIGITS);

  typedef struct packed {
    logic [VALUE_BITS-1:0] value;
    logic [RADIX_W-1:0]    radix;
  } rdc_in_t;

  typedef struct packed {
    logic [CHAR_W-1:0] digit_char;
    logic              last_digit;
    logic              base_error;
  } rdc_out_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } rdc_state_e;

  // Map a remainder to its lower-case ASCII digit.
  function automatic logic [CHAR_W-1:0] rdc_digit_char(input logic [REM_W-1:0] d);
    logic [CHAR_W-1:0] c;
    case (d)
      4'd0:    c = 7'h30;
      4'd1:    c = 7'h31;
      4'd2:    c = 7'h32;
      4'd3:    c = 7'h33;
      4'd4:    c = 7'h34;
      4'd5:    c = 7'h35;
      4'd6:    c = 7'h36;
      4'd7:    c = 7'h37;
      4'd8:    c = 7'h38;
      4'd9:    c = 7'h39;
      4'd10:   c = 7'h61;
      4'd11:   c = 7'h62;
      4'd12:   c = 7'h63;
      4'd13:   c = 7'h64;
      4'd14:   c = 7'h65;
      4'd15:   c = 7'h66;
      default: c = 7'h30;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

@@ hw/rtl/rdc_div_step.sv @@
// Restoring divider slice: resolves STEP_BITS quotient bits against a small radix.
`default_nettype none

module rdc_div_step (
  input  wire logic [rdc_pkg::REM_W-1:0]     rem_i,
  input  wire logic [rdc_pkg::STEP_BITS-1:0] bits_i,
  input  wire logic [rdc_pkg::REM_W:0]       radix_i,
  output logic      [rdc_pkg::STEP_BITS-1:0] quot_o,
  output logic      [rdc_pkg::REM_W-1:0]     rem_o
);
  import rdc_pkg::*;

  always_comb begin
    logic [REM_W:0]   trial;
    logic [REM_W-1:0] r;
    r      = rem_i;
    quot_o = '0;
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      trial = {r, bits_i[i]};
      if (trial >= radix_i) begin
        trial     = trial - radix_i;
        quot_o[i] = 1'b1;
      end
      // Remainder stays below radix, so it fits REM_W bits.
      r = trial[REM_W-1:0];
    end
    rem_o = r;
  end

endmodule

`default_nettype wire

@@ hw/rtl/radix_digit_converter_top.sv @@
// Top level of the radix digit converter: sequencer, digit stack and output register.
`default_nettype none

// Converts a 16-bit unsigned value into lower-case ASCII digits in base 2..16,
// most significant digit first, one result beat per cycle on valid_o, with
// last_digit set on the final beat. A beat is accepted at start_i & !busy_o.
// The receiver cannot stall: every result is on out_o for exactly one cycle
// and must be captured then. A base outside 2..16 gives one beat with
// base_error and last_digit set and digit_char 0, the cycle after the start,
// and the block stays ready. For a valid base the value is divided repeatedly
// by one shared restoring divider slice that resolves four quotient bits per
// cycle, and each remainder is kept as a digit; the remainders are stacked and
// then played out in reverse, one per cycle. busy_o stays high while an item
// is divided and played out, so no new value is taken before its last digit.
// The last result beat appears in the cycle that busy_o drops, and a new start
// is taken in that same cycle.

module radix_digit_converter_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  input  wire rdc_pkg::rdc_in_t in_i,
  output logic                  busy_o,
  output logic                  valid_o,
  output rdc_pkg::rdc_out_t     out_o
);
  import rdc_pkg::*;

  rdc_state_e state_q, state_d;

  // Working dividend: quotient bits shift in from the bottom.
  logic [VALUE_BITS-1:0] work_q;
  logic [REM_W-1:0]      rem_q;
  logic [REM_W:0]        radix_q;
  logic [STEP_CNT_W-1:0] step_q;
  logic [DIG_IDX_W-1:0]  wr_q;
  logic [DIG_IDX_W-1:0]  rd_q;
  logic [REM_W-1:0]      dig_q [MAX_DIGITS];

  logic                  valid_q, valid_d;
  rdc_out_t              out_q, out_d;

  logic                  accept;
  logic                  radix_ok;
  logic [STEP_BITS-1:0]  quot_bits;
  logic [REM_W-1:0]      rem_next;
  logic [VALUE_BITS-1:0] work_next;
  logic                  last_step;
  logic                  div_done;

  assign accept    = start_i && (state_q == ST_IDLE);
  assign radix_ok  = (in_i.radix >= RADIX_W'(2)) && (in_i.radix <= RADIX_W'(MAX_RADIX));
  assign work_next = {work_q[VALUE_BITS-STEP_BITS-1:0], quot_bits};
  assign last_step = (step_q == STEP_CNT_W'(DIV_STEPS - 1));
  assign div_done  = last_step &&
                     ((work_next == '0) || (wr_q == DIG_IDX_W'(MAX_DIGITS - 1)));

  rdc_div_step u_div_step (
    .rem_i  (rem_q),
    .bits_i (work_q[VALUE_BITS-1 -: STEP_BITS]),
    .radix_i(radix_q),
    .quot_o (quot_bits),
    .rem_o  (rem_next)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && radix_ok) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (rd_q == '0) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs: result beat and busy.
  always_comb begin
    valid_d          = 1'b0;
    out_d.digit_char = rdc_digit_char(dig_q[rd_q]);
    out_d.last_digit = (rd_q == '0);
    out_d.base_error = 1'b0;
    busy_o           = 1'b1;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
        if (accept && !radix_ok) begin
          valid_d          = 1'b1;
          out_d.digit_char = '0;
          out_d.last_digit = 1'b1;
          out_d.base_error = 1'b1;
        end
      end
      ST_DIV: begin
        valid_d = 1'b0;
      end
      ST_EMIT: begin
        valid_d = 1'b1;
      end
      default: begin
        busy_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      valid_q <= 1'b0;
      step_q  <= '0;
      wr_q    <= '0;
      rd_q    <= '0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
      case (state_q)
        ST_IDLE: begin
          step_q <= '0;
          wr_q   <= '0;
        end
        ST_DIV: begin
          step_q <= step_q + STEP_CNT_W'(1);
          if (last_step) begin
            if (div_done) rd_q <= wr_q;
            else          wr_q <= wr_q + DIG_IDX_W'(1);
          end
        end
        ST_EMIT: begin
          // Advance toward the least significant digit.
          rd_q <= rd_q - DIG_IDX_W'(1);
        end
        default: begin
          step_q <= '0;
        end
      endcase
    end
  end

  // Datapath: dividend, remainder, radix and digit stack.
  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    if (accept) begin
      work_q  <= in_i.value;
      rem_q   <= '0;
      radix_q <= in_i.radix[REM_W:0];
    end else if (state_q == ST_DIV) begin
      work_q <= work_next;
      if (last_step) begin
        // Push the finished digit; restart the divider on the quotient.
        dig_q[wr_q] <= rem_next;
        rem_q       <= '0;
      end else begin
        rem_q <= rem_next;
      end
    end
  end

  assign valid_o = valid_q;
  assign out_o   = out_q;

endmodule

`default_nettype wire
